// ===== rtl/multi_queue_overwrite_round_robin_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-queue overwrite round-robin core
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_OVERWRITE_ROUND_ROBIN_CORE_MACROS_SVH
`define MULTI_QUEUE_OVERWRITE_ROUND_ROBIN_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is applied
`define MQOR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied
`define MQOR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mqor_pkg.sv =====
// ----------------------------------------------------------------------------
// mqor_pkg
// Sizes, payload types and control structs of the multi-queue core.
// ----------------------------------------------------------------------------
package mqor_pkg;

    localparam int CHANNELS = 8;
    localparam int SLOTS    = 4;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DEPTH  = CHANNELS * SLOTS;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SEND    = 1'b1;

    typedef struct packed {
        logic        command;
        logic [2:0]  channel;
        logic [31:0] value_word;
        logic [31:0] timestamp;
    } item_t;

    typedef struct packed {
        logic        sent;
        logic [2:0]  out_channel;
        logic [31:0] out_value;
        logic [31:0] out_timestamp;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_enqueue;
        logic scan_step;
        logic load_out;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic head_hit;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/mqor_item_if.sv =====
// ----------------------------------------------------------------------------
// mqor_item_if
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface mqor_item_if;
    logic            valid;
    logic            ready;
    mqor_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/mqor_result_if.sv =====
// ----------------------------------------------------------------------------
// mqor_result_if
// Valid/ready channel carrying one send result.
// ----------------------------------------------------------------------------
interface mqor_result_if;
    logic              valid;
    logic              ready;
    mqor_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/mqor_datapath.sv =====
// ----------------------------------------------------------------------------
// mqor_datapath
// Ring pointers, slot valid bits, sample memory and output register.
// ----------------------------------------------------------------------------
module mqor_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  mqor_pkg::ctrl_t   ctrl,
    output mqor_pkg::stat_t   stat,
    input  mqor_pkg::item_t   item_in,
    output logic              out_valid,
    input  logic              out_ready,
    output mqor_pkg::result_t out_data
);

    localparam int CH_W   = mqor_pkg::CH_W;
    localparam int SLOT_W = mqor_pkg::SLOT_W;
    localparam int IDX_W  = mqor_pkg::IDX_W;
    localparam int DEPTH  = mqor_pkg::DEPTH;

    // latched item
    logic [CH_W-1:0]   item_ch_reg;
    logic              item_ok_reg;
    logic [31:0]       item_value_reg;
    logic [31:0]       item_time_reg;

    // ring state
    logic [SLOT_W-1:0] wp_reg [mqor_pkg::CHANNELS];
    logic [SLOT_W-1:0] rp_reg [mqor_pkg::CHANNELS];
    logic [DEPTH-1:0]  valid_reg;
    logic [CH_W-1:0]   next_ch_reg;

    // scan state
    logic [CH_W-1:0]   scan_q_reg;
    logic [CH_W-1:0]   scan_cnt_reg;
    logic              hit_reg;

    // sample memory, value in the upper half
    logic [63:0]       mem [DEPTH];
    logic [63:0]       rd_data_reg;

    logic              out_valid_reg;
    mqor_pkg::result_t out_data_reg;

    logic [CH_W-1:0]   ptr_addr;
    logic [SLOT_W-1:0] wp_cur;
    logic [SLOT_W-1:0] rp_cur;
    logic [SLOT_W-1:0] wp_inc;
    logic [SLOT_W-1:0] rp_inc;
    logic [IDX_W-1:0]  base_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  head_idx;
    logic [IDX_W-1:0]  after_idx;
    logic [CH_W-1:0]   q_inc;
    logic              head_hit;

    // one pointer read port: enqueue channel or scan channel
    assign ptr_addr  = ctrl.do_enqueue ? item_ch_reg : scan_q_reg;
    assign wp_cur    = wp_reg[ptr_addr];
    assign rp_cur    = rp_reg[ptr_addr];
    assign wp_inc    = (wp_cur == SLOT_W'(mqor_pkg::SLOTS - 1)) ? '0 : wp_cur + SLOT_W'(1);
    assign rp_inc    = (rp_cur == SLOT_W'(mqor_pkg::SLOTS - 1)) ? '0 : rp_cur + SLOT_W'(1);
    assign base_idx  = IDX_W'(ptr_addr) * IDX_W'(mqor_pkg::SLOTS);
    assign wr_idx    = base_idx + IDX_W'(wp_cur);
    assign head_idx  = base_idx + IDX_W'(rp_cur);
    assign after_idx = base_idx + IDX_W'(rp_inc);
    assign q_inc     = (scan_q_reg == CH_W'(mqor_pkg::CHANNELS - 1)) ? '0
                                                                      : scan_q_reg + CH_W'(1);
    assign head_hit  = valid_reg[head_idx];

    assign stat.head_hit  = head_hit;
    assign stat.scan_last = (scan_cnt_reg == CH_W'(mqor_pkg::CHANNELS - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_ch_reg    <= CH_W'(item_in.channel);
            item_value_reg <= item_in.value_word;
            item_time_reg  <= item_in.timestamp;
        end
    end

    // ring pointers, valid bits and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < mqor_pkg::CHANNELS; c++)
            begin
                wp_reg[c] <= '0;
                rp_reg[c] <= '0;
            end
            valid_reg    <= '0;
            next_ch_reg  <= '0;
            scan_q_reg   <= '0;
            scan_cnt_reg <= '0;
            hit_reg      <= 1'b0;
            item_ok_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.load_item)
            begin
                item_ok_reg  <= (int'(item_in.channel) < mqor_pkg::CHANNELS);
                scan_q_reg   <= next_ch_reg;
                scan_cnt_reg <= '0;
            end
            if (ctrl.do_enqueue && item_ok_reg)
            begin
                valid_reg[wr_idx] <= 1'b1;
                // full ring: drop the oldest entry
                if ((wp_cur == rp_cur) && valid_reg[after_idx])
                begin
                    rp_reg[ptr_addr] <= rp_inc;
                end
                wp_reg[ptr_addr] <= wp_inc;
            end
            if (ctrl.scan_step)
            begin
                hit_reg <= head_hit;
                if (head_hit)
                begin
                    valid_reg[head_idx] <= 1'b0;
                    rp_reg[ptr_addr]    <= rp_inc;
                    next_ch_reg         <= q_inc;
                end
                else
                begin
                    scan_q_reg   <= q_inc;
                    scan_cnt_reg <= scan_cnt_reg + CH_W'(1);
                end
            end
        end
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (ctrl.do_enqueue && item_ok_reg)
        begin
            mem[wr_idx] <= {item_value_reg, item_time_reg};
        end
        if (ctrl.scan_step && head_hit)
        begin
            rd_data_reg <= mem[head_idx];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_data_reg.sent          <= hit_reg;
            out_data_reg.out_channel   <= hit_reg ? 3'(scan_q_reg) : 3'd0;
            out_data_reg.out_value     <= hit_reg ? rd_data_reg[63:32] : 32'd0;
            out_data_reg.out_timestamp <= hit_reg ? rd_data_reg[31:0] : 32'd0;
        end
    end

endmodule

// ===== rtl/mqor_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqor_ctrl
// Sequencer: take an item, then enqueue it, or scan and hand the result over.
// ----------------------------------------------------------------------------
module mqor_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            item_send,
    output logic            item_ready,
    input  mqor_pkg::stat_t stat,
    output mqor_pkg::ctrl_t ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ENQ  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        state_next      = state_reg;
        ctrl.load_item  = 1'b0;
        ctrl.do_enqueue = 1'b0;
        ctrl.scan_step  = 1'b0;
        ctrl.load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = (item_send == mqor_pkg::CMD_SEND) ? ST_SCAN : ST_ENQ;
                end
            end
            ST_ENQ:
            begin
                ctrl.do_enqueue = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.head_hit || stat.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/multi_queue_overwrite_round_robin_core.sv =====
// ----------------------------------------------------------------------------
// multi_queue_overwrite_round_robin_core
// Per-channel sample rings, overwrite-oldest, round-robin send.
// ----------------------------------------------------------------------------
// Usage:
//   item   : command items in. command 0 enqueues value_word and timestamp on
//            the ring of channel; command 1 asks for one entry to be sent.
//   result : one transfer per send command, none per enqueue. sent = 0 with
//            all other fields zero when every ring is empty.
// Timing:
//   An enqueue transfer occupies the block through accept and ring write.
//   A send scans one ring per cycle from the round-robin pointer, visiting
//   k = 1..CHANNELS (8 here) rings, and the result is registered once the
//   sequencer leaves its done state with the output register free.
// Reset:
//   Every slot is marked empty, all ring pointers return to slot 0 and the
//   round-robin pointer to channel 0. The sample memory itself is not cleared.
// Stall:
//   A result waits in the output register while result.ready is low; the
//   block keeps taking items meanwhile, and a further send result holds in
//   the sequencer until the register is free.
// ----------------------------------------------------------------------------
module multi_queue_overwrite_round_robin_core (
    input  logic          clk,
    input  logic          rst_n,
    mqor_item_if.sink     item,
    mqor_result_if.source result
);

    mqor_pkg::ctrl_t ctrl;
    mqor_pkg::stat_t stat;

    // sequencer: decides enqueue or scan, and when to hand over the result
    mqor_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_send  (item.payload.command),
        .item_ready (item.ready),
        .stat       (stat),
        .ctrl       (ctrl)
    );

    // rings, sample memory and the output register
    mqor_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .item_in   (item.payload),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.payload)
    );

endmodule

// ===== rtl/mqor_checker.sv =====
// ----------------------------------------------------------------------------
// mqor_checker
// Port-level checks of the multi-queue core, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_queue_overwrite_round_robin_core_macros.svh"

module mqor_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_sent,
    input logic [2:0]  out_channel,
    input logic [31:0] out_value,
    input logic [31:0] out_timestamp
);

    // a stalled result holds its payload
    `MQOR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_timestamp) && $stable(out_channel) && $stable(out_sent), "stalled result changed")

    // an empty send carries zero fields
    `MQOR_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && !out_sent, (out_channel == 3'd0) && (out_value == 32'd0) && (out_timestamp == 32'd0), "empty result has non-zero fields")

    // every accepted item leaves the block busy in the following cycle
    `MQOR_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready, "input ready straight after a transfer")

    // a new result is only produced while the sequencer is busy
    `MQOR_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "result appeared while idle")

endmodule

bind multi_queue_overwrite_round_robin_core mqor_checker u_mqor_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_sent      (result.payload.sent),
    .out_channel   (result.payload.out_channel),
    .out_value     (result.payload.out_value),
    .out_timestamp (result.payload.out_timestamp)
);
